// ===== design/lzsd_pkg.sv =====
// Package for the LZSS stream decoder: history size, state and phase codes.
// No dependencies.
`timescale 1ns / 1ps

package lzsd_pkg;

  localparam int unsigned HistDepth = 4096;

  // Top level control states, one-hot.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_RUN   = 4'b0010,
    S_COPY  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  // What the next input word is.
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_ITEM = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

endpackage

// ===== design/lzsd_hist_ram.sv =====
// History RAM of the LZSS stream decoder: one write port, one registered read port.
// Depends on lzsd_pkg for the default depth.
`timescale 1ns / 1ps

module lzsd_hist_ram #(
  parameter int unsigned DEPTH = lzsd_pkg::HistDepth,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);
  import lzsd_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lzss_stream_decoder.sv =====
// LZSS stream decoder, top level: input parsing, copy engine, output register.
// Depends on lzsd_pkg and lzsd_hist_ram.
`timescale 1ns / 1ps
// A literal word shows at the output in the cycle after it is accepted.
// Flag and pair-high words give no output. A pair-low word starts a copy:
// each copied word is read from the history RAM into its read register and
// then committed to the output register, one word per cycle unless it stalls.
// Reset: control state clears at once; a clearing pass over all HISTORY_DEPTH
// (4096) slots then zeroes the history, with in_ready_o low throughout.

module lzss_stream_decoder #(
  parameter int unsigned HISTORY_DEPTH = lzsd_pkg::HistDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_stream_o,
  output logic       last_of_run_o
);
  import lzsd_pkg::*;

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);

  // Control state
  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [7:0]       flag_q, flag_d;
  logic [3:0]       items_q, items_d;
  logic [7:0]       high_q, high_d;
  logic [AddrW-1:0] wp_q, wp_d;       // next history slot to write
  logic [AddrW-1:0] clr_q, clr_d;     // clearing pass address

  // Copy engine: issue side and commit side of the registered RAM read
  logic [AddrW-1:0] rp_q, rp_d;       // next source slot to read
  logic [4:0]       iss_left_q, iss_left_d;
  logic [4:0]       cmt_left_q, cmt_left_d;
  logic             rv_q, rv_d;       // read data waiting to commit
  logic             fwd_q;            // read hit the slot written that cycle
  logic [7:0]       fwd_data_q;

  // Output register
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             oeos_q, oeos_d;
  logic             olast_q, olast_d;

  // RAM ports
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic [7:0]       copy_data;

  logic             out_free, in_acc, run_acc;
  logic             is_lit, is_high, is_low, is_end;
  logic             commit, issue;
  logic [11:0]      copy_dist;
  logic [3:0]       items_dec;

  lzsd_hist_ram #(
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // A distance-one copy reads the slot being written in the same cycle.
  assign copy_data = fwd_q ? fwd_data_q : ram_rdata;

  assign out_free = !ovalid_q || out_ready_i;
  // Once finished, every word is taken and dropped.
  assign in_ready_o = ((state_q == S_RUN) && out_free) || (state_q == S_DONE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign run_acc  = in_acc && (state_q == S_RUN);

  // Phase value 3 cannot occur; it decodes as a flag word.
  always_comb begin
    is_lit  = 1'b0;
    is_high = 1'b0;
    is_low  = 1'b0;
    case (phase_q)
      PH_ITEM: begin
        is_lit  = !flag_q[0];
        is_high = flag_q[0];
      end
      PH_LOW:  is_low = 1'b1;
      default: ;
    endcase
  end

  assign is_end    = is_low && (in_byte_i[3:0] == 4'd0);
  assign copy_dist = {high_q, in_byte_i[7:4]};
  assign items_dec = items_q - 4'd1;

  // A byte commits when its read data is back and the output can take it.
  // The next read goes out only when the pending one commits, so a read
  // never sees a slot that is still to be written by an older byte.
  assign commit = (state_q == S_COPY) && rv_q && out_free;
  assign issue  = (state_q == S_COPY) && (iss_left_q != 5'd0) && (!rv_q || commit);
  assign ram_re = issue;

  // One write port: clearing pass, literals, copied bytes.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = in_byte_i;
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = 8'd0;
    end else if (run_acc && is_lit) begin
      ram_we    = 1'b1;
    end else if (commit) begin
      ram_we    = 1'b1;
      ram_wdata = copy_data;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    flag_d     = flag_q;
    items_d    = items_q;
    high_d     = high_q;
    wp_d       = wp_q;
    clr_d      = clr_q;
    rp_d       = rp_q;
    iss_left_d = iss_left_q;
    cmt_left_d = cmt_left_q;
    rv_d       = rv_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    obyte_d    = obyte_q;
    oeos_d     = oeos_q;
    olast_d    = olast_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (run_acc) begin
          if (is_lit || (is_low && !is_end)) begin
            // consume one item of the group
            flag_d  = {1'b0, flag_q[7:1]};
            items_d = items_dec;
            phase_d = (items_dec == 4'd0) ? PH_FLAG : PH_ITEM;
          end
          if (is_lit) begin
            wp_d     = wp_q + AddrW'(1);
            ovalid_d = 1'b1;
            obyte_d  = in_byte_i;
            oeos_d   = 1'b0;
            olast_d  = 1'b1;
          end else if (is_high) begin
            high_d  = in_byte_i;
            phase_d = PH_LOW;
          end else if (is_end) begin
            state_d  = S_DONE;
            ovalid_d = 1'b1;
            obyte_d  = 8'd0;
            oeos_d   = 1'b1;
            olast_d  = 1'b1;
          end else if (is_low) begin
            state_d    = S_COPY;
            rp_d       = wp_q - AddrW'(copy_dist) - AddrW'(1);
            iss_left_d = {1'b0, in_byte_i[3:0]} + 5'd1;
            cmt_left_d = {1'b0, in_byte_i[3:0]} + 5'd1;
          end else begin
            flag_d  = in_byte_i;
            items_d = 4'd8;
            phase_d = PH_ITEM;
          end
        end
      end
      S_COPY: begin
        if (issue) begin
          rp_d       = rp_q + AddrW'(1);
          iss_left_d = iss_left_q - 5'd1;
        end
        if (commit) begin
          wp_d       = wp_q + AddrW'(1);
          cmt_left_d = cmt_left_q - 5'd1;
          ovalid_d   = 1'b1;
          obyte_d    = copy_data;
          oeos_d     = 1'b0;
          olast_d    = (cmt_left_q == 5'd1);
          if (cmt_left_q == 5'd1) begin
            state_d = S_RUN;
          end
        end
        if (issue) begin
          rv_d = 1'b1;
        end else if (commit) begin
          rv_d = 1'b0;
        end
      end
      S_DONE: ;
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      phase_q    <= PH_FLAG;
      flag_q     <= 8'd0;
      items_q    <= 4'd0;
      high_q     <= 8'd0;
      wp_q       <= '0;
      clr_q      <= '0;
      iss_left_q <= 5'd0;
      cmt_left_q <= 5'd0;
      rv_q       <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      flag_q     <= flag_d;
      items_q    <= items_d;
      high_q     <= high_d;
      wp_q       <= wp_d;
      clr_q      <= clr_d;
      iss_left_q <= iss_left_d;
      cmt_left_q <= cmt_left_d;
      rv_q       <= rv_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rp_q    <= rp_d;
    obyte_q <= obyte_d;
    oeos_q  <= oeos_d;
    olast_q <= olast_d;
    if (ram_re) begin
      fwd_q      <= ram_we && (ram_waddr == rp_q);
      fwd_data_q <= ram_wdata;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign out_byte_o      = obyte_q;
  assign end_of_stream_o = oeos_q;
  assign last_of_run_o   = olast_q;

  // Assertions
  a_no_input_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !in_ready_o)
    else $error("input taken during history clearing pass");

  a_copy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (cmt_left_q == iss_left_q + {4'd0, rv_q}))
    else $error("copy issue and commit counts out of step");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_DONE))
    else $error("decoder left the finished state");

  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oeos_q) |-> olast_q)
    else $error("end result not flagged as last of run");

endmodule
